[sv/three_channel_color_transform_macros.svh]
// Assertion macros used by the checker file of the color transform.
`ifndef THREE_CHANNEL_COLOR_TRANSFORM_MACROS_SVH
`define THREE_CHANNEL_COLOR_TRANSFORM_MACROS_SVH

// Same-cycle implication; the consequent may carry a fixed delay.
`define TCCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("tcct assertion failed");

// Next-cycle implication.
`define TCCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcct assertion failed");

`endif

[sv/tcct_pkg.sv]
`timescale 1ns / 1ps

package tcct_pkg;

	typedef struct packed {
		logic [15:0] chan_first;
		logic [15:0] chan_second;
		logic [15:0] chan_third;
	} tcct_pixel_t;

	typedef struct packed {
		logic [15:0] out_first;
		logic [15:0] out_second;
		logic [15:0] out_third;
	} tcct_result_t;

	// Wide enough for every intermediate sum of the matrices.
	typedef logic signed [21:0] tcct_acc_t;

	localparam logic [1:0] VARIANT_TOP  = 2'd0;
	localparam logic [1:0] VARIANT_TOP4 = 2'd1;
	localparam logic [1:0] VARIANT_AVG  = 2'd2;

	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_INVERSE = 1'b1;

	localparam logic REG_VARIANT   = 1'b0;
	localparam logic REG_DIRECTION = 1'b1;

	localparam tcct_acc_t UV_OFFSET = 22'sd32768;

	// ceil(2^19 / 3): exact floor division by 3 for values below 2^18
	localparam logic [17:0] DIV3_RECIP = 18'd174763;
	localparam int unsigned DIV3_SHIFT = 19;

	// Signed division by 2^k, truncating toward zero.
	function automatic tcct_acc_t tcct_sdiv_pow2(tcct_acc_t x, int unsigned k);
		logic [21:0] bias;
		bias = x[21] ? ((22'd1 << k) - 22'd1) : 22'd0;
		return (x + $signed(bias)) >>> k;
	endfunction

	// Signed division by 3 * 2^k, truncating toward zero; |x| >> k stays below 2^18.
	function automatic tcct_acc_t tcct_sdiv3(tcct_acc_t x, int unsigned k);
		logic [21:0] mag;
		logic [17:0] quo;
		logic [35:0] prod;
		logic [21:0] res;
		mag  = x[21] ? 22'(-x) : 22'(x);
		quo  = 18'(mag >> k);
		prod = quo * DIV3_RECIP;
		res  = 22'(prod >> DIV3_SHIFT);
		return x[21] ? -$signed(res) : $signed(res);
	endfunction

	function automatic logic [15:0] tcct_clamp16(tcct_acc_t x);
		logic [15:0] res;
		if (x[21]) begin
			res = 16'd0;
		end else if (x > 22'sd65535) begin
			res = 16'hFFFF;
		end else begin
			res = x[15:0];
		end
		return res;
	endfunction

endpackage

[sv/tcct_calc.sv]
`timescale 1ns / 1ps

module tcct_calc import tcct_pkg::*; (
	input  logic [1:0]   variant,
	input  logic         direction,
	input  tcct_pixel_t  pixel,
	output tcct_result_t result
);

	tcct_acc_t a, b, c, u, v;
	tcct_acc_t r0, r1, r2;

	assign a = $signed({6'd0, pixel.chan_first});
	assign b = $signed({6'd0, pixel.chan_second});
	assign c = $signed({6'd0, pixel.chan_third});
	assign u = b - UV_OFFSET;
	assign v = c - UV_OFFSET;

	always_comb begin
		if (direction == DIR_FORWARD) begin
			case (variant)
				VARIANT_TOP4: r0 = c <<< 2;
				VARIANT_AVG:  r0 = tcct_sdiv3(a + b + c, 0);
				default:      r0 = c;
			endcase
			r1 = (a <<< 1) - (c <<< 1) + UV_OFFSET;
			r2 = a - (b <<< 1) + c + UV_OFFSET;
		end else begin
			case (variant)
				VARIANT_TOP4: begin
					r0 = tcct_sdiv_pow2(a + (u <<< 1) + 22'sd2, 2);
					r1 = tcct_sdiv_pow2(a + u - (v <<< 1) + 22'sd2, 2);
					r2 = tcct_sdiv_pow2(a + 22'sd2, 2);
				end
				VARIANT_AVG: begin
					// divide by 12 as a shift by 2 and then by 3
					r0 = tcct_sdiv3(a * 22'sd12 + u * 22'sd3 + (v <<< 1), 2);
					r1 = tcct_sdiv3(a * 22'sd3 - v, 0);
					r2 = tcct_sdiv3(a * 22'sd12 - u * 22'sd3 + (v <<< 1), 2);
				end
				default: begin
					r0 = tcct_sdiv_pow2((a <<< 1) + u, 1);
					r1 = tcct_sdiv_pow2((a <<< 2) + u - (v <<< 1), 2);
					r2 = a;
				end
			endcase
		end
	end

	assign result.out_first  = tcct_clamp16(r0);
	assign result.out_second = tcct_clamp16(r1);
	assign result.out_third  = tcct_clamp16(r2);

endmodule

[sv/three_channel_color_transform.sv]
`timescale 1ns / 1ps

// Three-channel color transform between sensor B/M/T and offset Y/U/V space.
// Input: pulse start with a pixel on the pixel port; the pixel is taken at
// any edge where start is high and busy is low. busy stays low, so a pixel
// may be offered in every cycle.
// Output: after a pixel is taken, it passes the input register and then the result
// register; done is then high for one cycle and result holds the three clamped
// channels. Results leave in pixel order at one per cycle; the receiver cannot hold
// them off, so there is no stall. Path: input register, then the matrix,
// divide-by-constant and clamp logic into the result register. Throughput: one pixel
// per cycle, set by the single registered pass through the matrix logic.
// Registers (APB, byte address 4*i): 0 matrix_variant, 1 direction.
// Change them only while no pixel is in flight.
// Reset clears both registers and the in-flight valid flags.

module three_channel_color_transform import tcct_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  tcct_pixel_t  pixel,
	output logic         done,
	output tcct_result_t result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [1:0]   variant_q;
	logic         direction_q;
	logic         valid_s1;
	tcct_pixel_t  pixel_s1;
	logic         done_q;
	tcct_result_t result_q;
	tcct_result_t calc_result;
	logic         reg_index;
	logic         reg_write;

	assign busy      = 1'b0;
	assign pready    = 1'b1;
	assign reg_index = paddr[2];
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q   <= VARIANT_TOP;
			direction_q <= DIR_FORWARD;
		end else if (reg_write) begin
			case (reg_index)
				REG_VARIANT:   variant_q   <= pwdata[1:0];
				REG_DIRECTION: direction_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_VARIANT:   prdata = {30'd0, variant_q};
			REG_DIRECTION: prdata = {31'd0, direction_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pixel_s1 <= pixel;
		end
		if (valid_s1) begin
			result_q <= calc_result;
		end
	end

	tcct_calc u_calc (
		.variant   (variant_q),
		.direction (direction_q),
		.pixel     (pixel_s1),
		.result    (calc_result)
	);

	assign done   = done_q;
	assign result = result_q;

endmodule

[sv/tcct_port_chk.sv]
`timescale 1ns / 1ps
`include "three_channel_color_transform_macros.svh"

module tcct_port_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// every taken pixel yields a result once it has passed the input and result registers
	`TCCT_ASSERT_SAME(a_latency, clk, arst_n, start && !busy, ##2 done)
	// no result without a pixel taken, counted back over the input and result registers
	`TCCT_ASSERT_SAME(a_no_spurious, clk, arst_n, done, $past(start && !busy, 2))
	// a direction write reads back on the next cycle
	`TCCT_ASSERT_NEXT(a_dir_readback, clk, arst_n,
		psel && penable && pwrite && pready && paddr[2],
		!paddr[2] || (prdata[0] == $past(pwdata[0])))
	// a variant write reads back on the next cycle
	`TCCT_ASSERT_NEXT(a_var_readback, clk, arst_n,
		psel && penable && pwrite && pready && !paddr[2],
		paddr[2] || (prdata[1:0] == $past(pwdata[1:0])))

endmodule

bind three_channel_color_transform tcct_port_chk u_port_chk (.*);
